### hdl/ipv6rx_pkg.sv
// ipv6rx_pkg: constants, verdict codes and protocol numbers for the IPv6
// receive header filter. No dependencies; used by the interfaces and the top level.
package ipv6rx_pkg;

	localparam int ADDR_ENTRIES     = 4;
	localparam int MIN_HEADER_BYTES = 40;
	localparam int ENTRY_W          = 2;
	localparam int LEN_W            = 16;
	localparam int ADDR_HALF_W      = 64;

	localparam logic [3:0] IP_VERSION_6 = 4'd6;

	localparam logic [7:0] NH_ICMPV6 = 8'd58;
	localparam logic [7:0] NH_UDP    = 8'd17;
	localparam logic [7:0] NH_TCP    = 8'd6;

	typedef enum logic {
		MODE_WRITE    = 1'b0,
		MODE_CLASSIFY = 1'b1
	} mode_t;

	typedef enum logic [3:0] {
		V_WRITE   = 4'd0,
		V_SHORT   = 4'd1,
		V_TRUNC   = 4'd2,
		V_NOTOURS = 4'd3,
		V_HOPEXP  = 4'd4,
		V_ICMP    = 4'd5,
		V_UDP     = 4'd6,
		V_TCP     = 4'd7,
		V_UNKNOWN = 4'd8
	} verdict_t;

endpackage

### hdl/ipv6rx_hdr_if.sv
// ipv6rx_hdr_if: valid/ready channel carrying one header or table-write item.
// Depends on ipv6rx_pkg for field widths.
interface ipv6rx_hdr_if;
	import ipv6rx_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   mode;
	logic [ENTRY_W-1:0]     entry_index;
	logic                   entry_valid;
	logic [ADDR_HALF_W-1:0] address_high;
	logic [ADDR_HALF_W-1:0] address_low;
	logic [LEN_W-1:0]       frame_length;
	logic [3:0]             version;
	logic [LEN_W-1:0]       payload_length;
	logic [7:0]             next_proto;
	logic [7:0]             hop_limit;

	modport source (
		output valid, mode, entry_index, entry_valid, address_high, address_low,
		       frame_length, version, payload_length, next_proto, hop_limit,
		input  ready
	);

	modport sink (
		input  valid, mode, entry_index, entry_valid, address_high, address_low,
		       frame_length, version, payload_length, next_proto, hop_limit,
		output ready
	);

endinterface

### hdl/ipv6rx_res_if.sv
// ipv6rx_res_if: valid/ready channel carrying one classification result.
// Depends on ipv6rx_pkg for field widths.
interface ipv6rx_res_if;
	import ipv6rx_pkg::*;

	logic               valid;
	logic               ready;
	logic [3:0]         verdict;
	logic [ENTRY_W-1:0] matched_entry;
	logic [LEN_W-1:0]   upper_length;

	modport source (
		output valid, verdict, matched_entry, upper_length,
		input  ready
	);

	modport sink (
		input  valid, verdict, matched_entry, upper_length,
		output ready
	);

endinterface

### hdl/ipv6_receive_header_filter.sv
// IPv6 receive header filter: each input transaction passes through the input register,
// then is classified into the result register.
// Throughput one transaction per cycle while result back-pressure does not stall; the address table
// compare is fully parallel over all entries, and a table write is seen by the very next item.
// Reset (arst_n low, asynchronous) clears all pipeline valids and the table
// valid bits; stored addresses are left as they are.
module ipv6_receive_header_filter (
	input  logic                clk,
	input  logic                arst_n,
	ipv6rx_hdr_if.sink          hdr,
	ipv6rx_res_if.source        result
);
	import ipv6rx_pkg::*;

	// input register
	logic                   valid_s1;
	logic                   mode_s1;
	logic [ENTRY_W-1:0]     entry_index_s1;
	logic                   entry_valid_s1;
	logic [ADDR_HALF_W-1:0] addr_hi_s1;
	logic [ADDR_HALF_W-1:0] addr_lo_s1;
	logic [LEN_W-1:0]       frame_len_s1;
	logic [3:0]             version_s1;
	logic [LEN_W-1:0]       payload_s1;
	logic [7:0]             next_proto_s1;
	logic [7:0]             hop_limit_s1;

	// address table
	logic [ADDR_HALF_W-1:0] tbl_hi_q  [ADDR_ENTRIES];
	logic [ADDR_HALF_W-1:0] tbl_lo_q  [ADDR_ENTRIES];
	logic [ADDR_ENTRIES-1:0] tbl_vld_q;

	// result register
	logic               res_valid_q;
	verdict_t           verdict_q;
	logic [ENTRY_W-1:0] match_q;
	logic [LEN_W-1:0]   upper_len_q;

	logic               advance;
	logic               take_in;
	logic [ADDR_ENTRIES-1:0] hit;
	logic               found;
	logic [ENTRY_W-1:0] match_idx;
	logic [LEN_W:0]     need_len;
	verdict_t           verdict_d;
	logic [ENTRY_W-1:0] match_d;
	logic [LEN_W-1:0]   upper_len_d;

	assign advance   = !res_valid_q || result.ready;
	assign hdr.ready = !valid_s1 || advance;
	assign take_in   = hdr.valid && hdr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			mode_s1        <= hdr.mode;
			entry_index_s1 <= hdr.entry_index;
			entry_valid_s1 <= hdr.entry_valid;
			addr_hi_s1     <= hdr.address_high;
			addr_lo_s1     <= hdr.address_low;
			frame_len_s1   <= hdr.frame_length;
			version_s1     <= hdr.version;
			payload_s1     <= hdr.payload_length;
			next_proto_s1  <= hdr.next_proto;
			hop_limit_s1   <= hdr.hop_limit;
		end
	end

	// parallel compare; lowest valid hit wins
	always_comb begin
		found     = 1'b0;
		match_idx = '0;
		for (int i = 0; i < ADDR_ENTRIES; i++) begin
			hit[i] = tbl_vld_q[i] && (tbl_hi_q[i] == addr_hi_s1) && (tbl_lo_q[i] == addr_lo_s1);
		end
		for (int i = ADDR_ENTRIES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found     = 1'b1;
				match_idx = ENTRY_W'(i);
			end
		end
	end

	// sum kept one bit wider so a large payload never wraps
	assign need_len = {1'b0, payload_s1} + (LEN_W+1)'(MIN_HEADER_BYTES);

	always_comb begin
		verdict_d   = V_WRITE;
		match_d     = '0;
		upper_len_d = '0;
		if (mode_s1 == MODE_CLASSIFY) begin
			if (frame_len_s1 < LEN_W'(MIN_HEADER_BYTES) || version_s1 != IP_VERSION_6) begin
				verdict_d = V_SHORT;
			end else if ({1'b0, frame_len_s1} < need_len) begin
				verdict_d = V_TRUNC;
			end else if (!found) begin
				verdict_d = V_NOTOURS;
			end else begin
				match_d = match_idx;
				if (hop_limit_s1 == 8'd0) begin
					verdict_d = V_HOPEXP;
				end else begin
					case (next_proto_s1)
						NH_ICMPV6: begin
							verdict_d   = V_ICMP;
							upper_len_d = payload_s1;
						end
						NH_UDP: begin
							verdict_d   = V_UDP;
							upper_len_d = payload_s1;
						end
						NH_TCP: begin
							verdict_d   = V_TCP;
							upper_len_d = payload_s1;
						end
						default: begin
							verdict_d = V_UNKNOWN;
						end
					endcase
				end
			end
		end
	end

	// table write happens as the write transaction leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (valid_s1 && advance && mode_s1 == MODE_WRITE) begin
			for (int i = 0; i < ADDR_ENTRIES; i++) begin
				if (32'(entry_index_s1) == i) begin
					tbl_vld_q[i] <= entry_valid_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && mode_s1 == MODE_WRITE) begin
			for (int i = 0; i < ADDR_ENTRIES; i++) begin
				if (32'(entry_index_s1) == i) begin
					tbl_hi_q[i] <= addr_hi_s1;
					tbl_lo_q[i] <= addr_lo_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			verdict_q   <= verdict_d;
			match_q     <= match_d;
			upper_len_q <= upper_len_d;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.verdict       = verdict_q;
	assign result.matched_entry = match_q;
	assign result.upper_length  = upper_len_q;

endmodule

### bench/ipv6rx_verdict_check.sv
// ipv6rx_verdict_check: watches the header and result channels of the IPv6 receive filter,
// predicts each verdict from its own copy of the local address table and compares.
// Depends on ipv6rx_pkg, ipv6rx_hdr_if and ipv6rx_res_if.
module ipv6rx_verdict_check (
	input  logic   clk,
	input  logic   arst_n,
	ipv6rx_hdr_if  hdr,
	ipv6rx_res_if  result,
	output int     mismatch_count,
	output int     pending_count
);
	import ipv6rx_pkg::*;

	typedef struct packed {
		logic [3:0]         verdict;
		logic [ENTRY_W-1:0] entry;
		logic [LEN_W-1:0]   length;
	} verdict_rec_t;

	logic [ADDR_HALF_W-1:0] local_addr_hi [ADDR_ENTRIES];
	logic [ADDR_HALF_W-1:0] local_addr_lo [ADDR_ENTRIES];
	logic                   local_addr_on [ADDR_ENTRIES];
	verdict_rec_t           expected_verdicts [$];

	function automatic verdict_rec_t filter_header(
		input logic                   mode,
		input logic [ENTRY_W-1:0]     index,
		input logic                   valid_bit,
		input logic [ADDR_HALF_W-1:0] hi,
		input logic [ADDR_HALF_W-1:0] lo,
		input logic [LEN_W-1:0]       frame,
		input logic [3:0]             version,
		input logic [LEN_W-1:0]       payload,
		input logic [7:0]             nh,
		input logic [7:0]             hops
	);
		verdict_rec_t       r;
		logic [LEN_W:0]     needed;
		logic               found;
		logic [ENTRY_W-1:0] hit;
		r.entry  = '0;
		r.length = '0;
		found    = 1'b0;
		hit      = '0;
		needed   = {1'b0, payload} + (LEN_W+1)'(MIN_HEADER_BYTES);
		if (mode == MODE_WRITE) begin
			if (int'(index) < ADDR_ENTRIES) begin
				local_addr_hi[index] = hi;
				local_addr_lo[index] = lo;
				local_addr_on[index] = valid_bit;
			end
			r.verdict = V_WRITE;
			return r;
		end
		if (int'(frame) < MIN_HEADER_BYTES || version != IP_VERSION_6) begin
			r.verdict = V_SHORT;
			return r;
		end
		// sum kept one bit wider, so a payload near the top never wraps
		if ({1'b0, frame} < needed) begin
			r.verdict = V_TRUNC;
			return r;
		end
		// walk downward so the lowest matching entry wins
		for (int i = ADDR_ENTRIES - 1; i >= 0; i--) begin
			if (local_addr_on[i] && local_addr_hi[i] == hi && local_addr_lo[i] == lo) begin
				found = 1'b1;
				hit   = ENTRY_W'(i);
			end
		end
		if (!found) begin
			r.verdict = V_NOTOURS;
			return r;
		end
		r.entry = hit;
		if (hops == 8'd0) begin
			r.verdict = V_HOPEXP;
			return r;
		end
		case (nh)
			NH_ICMPV6: r.verdict = V_ICMP;
			NH_UDP:    r.verdict = V_UDP;
			NH_TCP:    r.verdict = V_TCP;
			default:   r.verdict = V_UNKNOWN;
		endcase
		if (r.verdict != V_UNKNOWN)
			r.length = payload;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_rec_t got;
		verdict_rec_t want;
		if (!arst_n) begin
			for (int i = 0; i < ADDR_ENTRIES; i++)
				local_addr_on[i] = 1'b0;
			expected_verdicts.delete();
			pending_count = 0;
		end else begin
			// retire first: an expectation pushed at this edge cannot be due yet
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				got.verdict = result.verdict;
				got.entry   = result.matched_entry;
				got.length  = result.upper_length;
				if (expected_verdicts.size() == 0) begin
					$display("%0t: unexpected result: expected none, %s %0d entry %0d length %0d",
						$time, "actual verdict", got.verdict, got.entry, got.length);
					mismatch_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (got.verdict !== want.verdict) begin
						$display("%0t: verdict mismatch: expected %0d, actual %0d",
							$time, want.verdict, got.verdict);
						mismatch_count++;
					end
					if (got.entry !== want.entry) begin
						$display("%0t: matched_entry mismatch: expected %0d, actual %0d",
							$time, want.entry, got.entry);
						mismatch_count++;
					end
					if (got.length !== want.length) begin
						$display("%0t: upper_length mismatch: expected %0d, actual %0d",
							$time, want.length, got.length);
						mismatch_count++;
					end
				end
			end
			if (hdr.valid === 1'b1 && hdr.ready === 1'b1)
				expected_verdicts.push_back(filter_header(hdr.mode, hdr.entry_index,
					hdr.entry_valid, hdr.address_high, hdr.address_low, hdr.frame_length,
					hdr.version, hdr.payload_length, hdr.next_proto, hdr.hop_limit));
			pending_count = expected_verdicts.size();
		end
	end

endmodule

### bench/tb_top.sv
// tb_top: drives table writes and header classifications into the IPv6 receive filter,
// with random gaps and result back-pressure, and reports the verdict of the run.
// Depends on ipv6rx_pkg, both channel interfaces, the filter and ipv6rx_verdict_check.
module tb_top;
	import ipv6rx_pkg::*;

	typedef struct {
		logic                   mode;
		logic [ENTRY_W-1:0]     index;
		logic                   valid_bit;
		logic [ADDR_HALF_W-1:0] hi;
		logic [ADDR_HALF_W-1:0] lo;
		logic [LEN_W-1:0]       frame;
		logic [3:0]             version;
		logic [LEN_W-1:0]       payload;
		logic [7:0]             nh;
		logic [7:0]             hops;
	} hdr_item_t;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   stall_request;
	int   mismatch_count;
	int   pending_count;

	// what the stimulus has written, used to aim destinations at the table
	logic [ADDR_HALF_W-1:0] tbl_hi [ADDR_ENTRIES];
	logic [ADDR_HALF_W-1:0] tbl_lo [ADDR_ENTRIES];

	ipv6rx_hdr_if hdr_ch ();
	ipv6rx_res_if res_ch ();

	ipv6_receive_header_filter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr_ch),
		.result (res_ch)
	);

	ipv6rx_verdict_check u_verdict_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.hdr            (hdr_ch),
		.result         (res_ch),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#2400000;
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic hdr_item_t table_write(input int idx, input logic on,
			input logic [ADDR_HALF_W-1:0] hi, input logic [ADDR_HALF_W-1:0] lo);
		hdr_item_t it;
		it.mode      = MODE_WRITE;
		it.index     = ENTRY_W'(idx);
		it.valid_bit = on;
		it.hi        = hi;
		it.lo        = lo;
		it.frame     = LEN_W'($urandom);
		it.version   = 4'($urandom);
		it.payload   = LEN_W'($urandom);
		it.nh        = 8'($urandom);
		it.hops      = 8'($urandom);
		if (idx < ADDR_ENTRIES) begin
			tbl_hi[idx] = hi;
			tbl_lo[idx] = lo;
		end
		return it;
	endfunction

	function automatic hdr_item_t header(input logic [ADDR_HALF_W-1:0] hi,
			input logic [ADDR_HALF_W-1:0] lo, input int frame, input int version,
			input int payload, input logic [7:0] nh, input int hops);
		hdr_item_t it;
		it.mode      = MODE_CLASSIFY;
		it.index     = ENTRY_W'($urandom);
		it.valid_bit = 1'($urandom);
		it.hi        = hi;
		it.lo        = lo;
		it.frame     = LEN_W'(frame);
		it.version   = 4'(version);
		it.payload   = LEN_W'(payload);
		it.nh        = nh;
		it.hops      = 8'(hops);
		return it;
	endfunction

	function automatic logic [ADDR_HALF_W-1:0] rand_half();
		return {$urandom, $urandom};
	endfunction

	function automatic hdr_item_t random_header();
		hdr_item_t              it;
		int                     roll;
		int                     idx;
		int                     src;
		logic [ADDR_HALF_W-1:0] hi;
		logic [ADDR_HALF_W-1:0] lo;
		int                     payload;
		int                     needed;
		int                     frame;
		logic [7:0]             nh;
		roll = $urandom_range(99);
		idx  = $urandom_range(ADDR_ENTRIES - 1);
		if (roll < 15) begin
			src = $urandom_range(ADDR_ENTRIES - 1);
			// sometimes duplicate another entry to exercise lowest-match priority
			if ($urandom_range(3) == 0)
				return table_write(idx, $urandom_range(9) != 0, tbl_hi[src], tbl_lo[src]);
			return table_write(idx, $urandom_range(9) != 0, rand_half(), rand_half());
		end
		hi = tbl_hi[idx];
		lo = tbl_lo[idx];
		roll = $urandom_range(99);
		if (roll < 15) begin
			hi = rand_half();
			lo = rand_half();
		end else if (roll < 30) begin
			if ($urandom_range(1) == 0)
				hi[$urandom_range(ADDR_HALF_W - 1)] ^= 1'b1;
			else
				lo[$urandom_range(ADDR_HALF_W - 1)] ^= 1'b1;
		end
		roll = $urandom_range(99);
		if (roll < 75)
			payload = $urandom_range(1500);
		else if (roll < 85)
			payload = $urandom_range(65535);
		else
			payload = $urandom_range(65535, 65480);
		needed = payload + MIN_HEADER_BYTES;
		roll = $urandom_range(99);
		if (roll < 80)
			frame = needed + $urandom_range(20);
		else if (roll < 90)
			frame = needed - 1;
		else
			frame = $urandom_range(65535);
		if (frame > 65535)
			frame = 65535;
		roll = $urandom_range(99);
		if (roll < 30)
			nh = NH_ICMPV6;
		else if (roll < 55)
			nh = NH_UDP;
		else if (roll < 80)
			nh = NH_TCP;
		else
			nh = 8'($urandom);
		return header(hi, lo, frame,
			($urandom_range(9) == 0) ? $urandom_range(15) : 6, payload, nh,
			($urandom_range(9) == 0) ? 0 : $urandom_range(255, 1));
	endfunction

	task automatic send_header(input hdr_item_t it);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			hdr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		hdr_ch.valid          <= 1'b1;
		hdr_ch.mode           <= it.mode;
		hdr_ch.entry_index    <= it.index;
		hdr_ch.entry_valid    <= it.valid_bit;
		hdr_ch.address_high   <= it.hi;
		hdr_ch.address_low    <= it.lo;
		hdr_ch.frame_length   <= it.frame;
		hdr_ch.version        <= it.version;
		hdr_ch.payload_length <= it.payload;
		hdr_ch.next_proto     <= it.nh;
		hdr_ch.hop_limit      <= it.hops;
		// ready is settled mid-cycle; high there means the transaction completes next edge
		do @(negedge clk); while (hdr_ch.ready !== 1'b1);
		@(posedge clk);
	endtask

	// result side back-pressure, with an occasional long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_request) begin
				stall_request = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (90) @(posedge clk);
			end else begin
				res_ch.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [ADDR_HALF_W-1:0] c_hi;
		logic [ADDR_HALF_W-1:0] c_lo;
		arst_n                = 1'b0;
		stall_request         = 1'b0;
		send_idle_pct         = 17;
		recv_idle_pct         = 47;
		hdr_ch.valid          = 1'b0;
		hdr_ch.mode           = MODE_WRITE;
		hdr_ch.entry_index    = '0;
		hdr_ch.entry_valid    = 1'b0;
		hdr_ch.address_high   = '0;
		hdr_ch.address_low    = '0;
		hdr_ch.frame_length   = '0;
		hdr_ch.version        = '0;
		hdr_ch.payload_length = '0;
		hdr_ch.next_proto     = '0;
		hdr_ch.hop_limit      = '0;
		c_hi                  = rand_half();
		c_lo                  = rand_half();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every entry is written before any lookup; entry 2 repeats entry 0
		send_header(table_write(0, 1'b1, '1, '1));
		send_header(table_write(1, 1'b1, '0, '0));
		send_header(table_write(2, 1'b1, '1, '1));
		send_header(table_write(3, 1'b0, c_hi, c_lo));
		send_header(header('1, '1, 40, 6, 0, NH_ICMPV6, 255));
		send_header(header('0, '0, 65535, 6, 65495, NH_UDP, 1));
		send_header(header('0, '0, 65535, 6, 65496, NH_UDP, 1));
		send_header(header('0, '0, 65535, 6, 65535, NH_TCP, 9));
		send_header(header('0, '0, 39, 6, 0, NH_TCP, 9));
		send_header(header('0, '0, 0, 6, 0, NH_TCP, 9));
		send_header(header('0, '0, 100, 4, 0, NH_TCP, 9));
		send_header(header('0, '0, 100, 15, 0, NH_TCP, 9));
		send_header(header('0, '0, 100, 0, 0, NH_TCP, 9));
		send_header(header('0, '0, 100, 6, 60, NH_TCP, 9));
		send_header(header('0, '0, 100, 6, 61, NH_TCP, 9));
		send_header(header(c_hi, c_lo, 200, 6, 10, NH_UDP, 64));
		send_header(header(rand_half(), rand_half(), 200, 6, 10, NH_UDP, 64));
		send_header(header('1, '1, 200, 6, 10, NH_ICMPV6, 0));
		send_header(header('0, '0, 200, 6, 10, 8'd0, 64));
		send_header(header('0, '0, 200, 6, 10, 8'hff, 64));
		// dropping entry 0 leaves its duplicate in entry 2 as the lowest match
		send_header(table_write(0, 1'b0, '1, '1));
		send_header(header('1, '1, 200, 6, 10, NH_TCP, 64));
		send_header(table_write(3, 1'b1, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef));
		send_header(header(64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef, 40, 6, 0,
			NH_TCP, 1));

		repeat (210) send_header(random_header());

		send_idle_pct = 47;
		recv_idle_pct = 17;
		repeat (210) send_header(random_header());

		// back-to-back offers against a long hold-off fill the pipeline
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 1'b1;
		repeat (210) send_header(random_header());

		hdr_ch.valid <= 1'b0;
		@(posedge clk);
		for (int w = 0; w < 4000 && pending_count != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
